// File: sv/binomial_downsample_by_three_macros.svh
// Assertion helpers for the binomial downsample block.
`ifndef BINOMIAL_DOWNSAMPLE_BY_THREE_MACROS_SVH
`define BINOMIAL_DOWNSAMPLE_BY_THREE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication on the block clock
`define BDS3_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bds3 check failed");
// next-cycle implication on the block clock
`define BDS3_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bds3 check failed");
`else
`define BDS3_ASSERT_IMP(lbl, ante, cons)
`define BDS3_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: sv/bds3_pkg.sv
package bds3_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ONE_Q     = 1 << FRAC_BITS;

    localparam int COLOR_W = 16;
    localparam int NRM_W   = 13;
    localparam int DEP_W   = 16;

    // per-column partial sums
    localparam int CSUM_W = 21;
    localparam int NSUM_W = 17;
    localparam int DSUM_W = 21;
    localparam int RAM_W  = 3 * CSUM_W + 3 * NSUM_W + DSUM_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPERSAMPLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT  = 2'd2;

    localparam logic [10:0] RST_OUT_WIDTH  = 11'd640;
    localparam logic [12:0] RST_OUT_HEIGHT = 13'd480;
    localparam logic [12:0] ROW_LIMIT      = 13'd4096;

    // x / 3 == (x * RECIP3) >> RECIP3_SH for x below 2^16
    localparam logic [15:0] RECIP3    = 16'd43691;
    localparam int          RECIP3_SH = 17;

    // normaliser widths
    localparam int SQ_W   = 2 * NSUM_W;
    localparam int LEN_W  = SQ_W + 2;
    localparam int T_W    = NRM_W + 1;
    localparam int T2_W   = 2 * NRM_W;
    localparam int LO_W   = 18;
    localparam int HI_W   = LEN_W - LO_W;
    localparam int PLO_W  = T2_W + LO_W;
    localparam int PROD_W = T2_W + LEN_W;
    localparam int RHS_SH = 2 * (FRAC_BITS + 1);

    typedef struct packed {
        logic                    first_of_frame;
        logic [COLOR_W-1:0]      red_in;
        logic [COLOR_W-1:0]      green_in;
        logic [COLOR_W-1:0]      blue_in;
        logic [NRM_W-1:0]        normal_x_in;
        logic [NRM_W-1:0]        normal_y_in;
        logic [NRM_W-1:0]        normal_z_in;
        logic signed [DEP_W-1:0] depth_in;
    } t_in;

    typedef struct packed {
        logic [COLOR_W-1:0]      red_out;
        logic [COLOR_W-1:0]      green_out;
        logic [COLOR_W-1:0]      blue_out;
        logic [NRM_W-1:0]        normal_x_out;
        logic [NRM_W-1:0]        normal_y_out;
        logic [NRM_W-1:0]        normal_z_out;
        logic signed [DEP_W-1:0] depth_out;
        logic                    zero_normal;
        logic                    end_of_frame;
    } t_out;

endpackage

// File: sv/binomial_downsample_by_three.sv
// Binomial 3x3 downsample by three. In supersample mode each sample steps through accept,
// address, RAM read and read-modify-write of the per-column sums held in one
// MAX_OUT_WIDTH-deep RAM; the sample that closes a 3x3 block then runs the normal
// normaliser: squares, length, and a bit-serial search of 13 result bits per component,
// with a partial-product and compare step for a candidate in range. In bypass a sample
// steps through accept, address and output. The block takes one request at a time;
// a finished result sits in the output register and does not hold off the next request.
// The sum RAM is not cleared after reset.
`include "binomial_downsample_by_three_macros.svh"

module binomial_downsample_by_three #(
    parameter int MAX_OUT_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bds3_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bds3_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bds3_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bds3_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bds3_pkg::*;

    localparam int ADDR_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int IC_W   = $clog2(3 * MAX_OUT_WIDTH + 1);
    localparam int QW     = IC_W + 16;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ADDR = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_MOD  = 4'd3;
    localparam logic [3:0] S_BYP  = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_LEN  = 4'd6;
    localparam logic [3:0] S_T2   = 4'd7;
    localparam logic [3:0] S_P1   = 4'd8;
    localparam logic [3:0] S_P2   = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    // configuration
    logic        r_ss;
    logic [10:0] r_ow;
    logic [12:0] r_oh;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ss <= 1'b1;
            r_ow <= RST_OUT_WIDTH;
            r_oh <= RST_OUT_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SUPERSAMPLE: r_ss <= i_cfg_data[0];
                CFG_OUT_WIDTH:   r_ow <= i_cfg_data[10:0];
                CFG_OUT_HEIGHT:  r_oh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [10:0]     ow_c;
    logic [12:0]     oh_c;
    logic [10:0]     ow_m1;
    logic [12:0]     oh_m1;
    logic [IC_W-1:0] in_w;

    always_comb begin
        if (r_ow == 11'd0) begin
            ow_c = 11'd1;
        end else if ({2'b0, r_ow} > 13'(MAX_OUT_WIDTH)) begin
            ow_c = 11'(MAX_OUT_WIDTH);
        end else begin
            ow_c = r_ow;
        end
        if (r_oh == 13'd0) begin
            oh_c = 13'd1;
        end else if (r_oh > ROW_LIMIT) begin
            oh_c = ROW_LIMIT;
        end else begin
            oh_c = r_oh;
        end
    end

    assign ow_m1 = ow_c - 11'd1;
    assign oh_m1 = oh_c - 13'd1;
    assign in_w  = r_ss ? IC_W'({2'b0, ow_c} + {1'b0, ow_c, 1'b0}) : IC_W'(ow_c);

    // control
    logic [3:0]        r_state, n_state;
    logic [IC_W-1:0]   r_ic;
    logic [1:0]        r_rp;
    logic [11:0]       r_orow;
    logic [1:0]        r_k;
    logic [3:0]        r_bit;
    logic              r_out_valid;

    logic              in_acc;
    logic              out_free;
    logic              out_load;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == S_BYP || r_state == S_OUT) && out_free;

    // counter values at accept
    logic [IC_W-1:0] acc_ic0, acc_ic;
    logic [1:0]      acc_rp;
    logic [11:0]     acc_orow;

    always_comb begin
        acc_ic0  = i_in_data.first_of_frame ? '0 : r_ic;
        acc_ic   = (acc_ic0 >= in_w) ? '0 : acc_ic0;
        acc_rp   = (i_in_data.first_of_frame || !r_ss) ? 2'd0 : r_rp;
        acc_orow = i_in_data.first_of_frame ? 12'd0 : r_orow;
    end

    // counter advance after a sample
    logic [IC_W:0]   ic_inc;
    logic            wrap;
    logic [IC_W-1:0] adv_ic;
    logic [1:0]      adv_rp;
    logic [11:0]     adv_orow;
    logic [12:0]     orow_inc;

    always_comb begin
        ic_inc   = {1'b0, r_ic} + (IC_W+1)'(1);
        wrap     = ic_inc >= {1'b0, in_w};
        orow_inc = {1'b0, r_orow} + 13'd1;
        adv_ic   = wrap ? '0 : ic_inc[IC_W-1:0];
        adv_rp   = r_rp;
        adv_orow = r_orow;
        if (wrap) begin
            if (r_ss && r_rp < 2'd2) begin
                adv_rp = r_rp + 2'd1;
            end else begin
                adv_rp   = 2'd0;
                adv_orow = (orow_inc >= oh_c) ? 12'd0 : orow_inc[11:0];
            end
        end
    end

    // column and sub-column from the input column
    logic [QW-1:0]     q3;
    logic [IC_W-1:0]   qq;
    logic [1:0]        sx_calc;

    assign q3      = QW'(r_ic) * QW'(RECIP3);
    assign qq      = IC_W'(q3 >> RECIP3_SH);
    assign sx_calc = 2'(r_ic - (qq + {qq[IC_W-2:0], 1'b0}));

    // payload registers
    t_in               r_in;
    logic [ADDR_W-1:0] r_col;
    logic [1:0]        r_sx;
    t_out              r_res;
    t_out              r_out;
    t_out              res_done;

    // sum RAM
    logic [RAM_W-1:0] rd_data;
    logic [RAM_W-1:0] wr_data;
    logic             ram_we;

    assign ram_we = (r_state == S_MOD);

    bds3_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata (wr_data),
        .i_raddr (r_col),
        .o_rdata (rd_data)
    );

    // read-modify-write of one column entry
    logic [COLOR_W-1:0]       pix [3];
    logic [NRM_W-1:0]         nrm [3];
    logic [CSUM_W-1:0]        new_c [3];
    logic [NSUM_W-1:0]        new_n [3];
    logic signed [DSUM_W-1:0] new_d;
    logic signed [DSUM_W-1:0] dep_ext;
    logic [CSUM_W-1:0]        c_rnd [3];
    logic [DSUM_W-1:0]        d_rnd;
    logic [1:0]               sh;
    logic                     fresh;
    logic                     done_blk;
    logic                     eof_ss;
    logic                     eof_byp;

    always_comb begin
        pix[0]  = r_in.red_in;
        pix[1]  = r_in.green_in;
        pix[2]  = r_in.blue_in;
        nrm[0]  = r_in.normal_x_in;
        nrm[1]  = r_in.normal_y_in;
        nrm[2]  = r_in.normal_z_in;
        sh      = {1'b0, r_sx == 2'd1} + {1'b0, r_rp == 2'd1};
        fresh   = (r_sx == 2'd0) && (r_rp == 2'd0);
        dep_ext = DSUM_W'(r_in.depth_in);
        for (int i = 0; i < 3; i++) begin
            new_c[i] = (fresh ? '0 : rd_data[CSUM_W*i +: CSUM_W])
                     + (CSUM_W'(pix[i]) << sh);
            new_n[i] = (fresh ? '0 : rd_data[3*CSUM_W + NSUM_W*i +: NSUM_W])
                     + (NSUM_W'(nrm[i]) << sh);
            c_rnd[i] = new_c[i] + CSUM_W'(8);
        end
        new_d    = (fresh ? '0 : $signed(rd_data[RAM_W-1 -: DSUM_W])) + (dep_ext <<< sh);
        d_rnd    = new_d + DSUM_W'(8);
        wr_data  = {new_d, new_n[2], new_n[1], new_n[0], new_c[2], new_c[1], new_c[0]};
        done_blk = (r_sx == 2'd2) && (r_rp == 2'd2);
        eof_ss   = (16'(r_col) == 16'(ow_m1)) && ({1'b0, r_orow} == oh_m1);
        eof_byp  = (16'(r_ic) == 16'(ow_m1)) && ({1'b0, r_orow} == oh_m1);
    end

    // normaliser: bit-serial search for round(ONE_Q * s / |s|)
    logic [NSUM_W-1:0] r_s [3];
    logic [SQ_W-1:0]   r_sq [3];
    logic [LEN_W-1:0]  r_len2;
    logic [NRM_W-1:0]  r_r;
    logic [NRM_W-1:0]  r_cand;
    logic [T2_W-1:0]   r_t2;
    logic [PLO_W-1:0]  r_plo;
    logic [NRM_W-1:0]  r_nres [3];
    logic              r_zero;

    logic [LEN_W-1:0]  len2;
    logic [NRM_W-1:0]  cand;
    logic              cand_ok;
    logic [T_W-1:0]    t;
    logic [2*T_W-1:0]  t2_full;
    logic [PLO_W-1:0]  phi;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rhs;
    logic              keep;
    logic [NRM_W-1:0]  step_r;
    logic              step_adv;

    always_comb begin
        len2     = LEN_W'(r_sq[0]) + LEN_W'(r_sq[1]) + LEN_W'(r_sq[2]);
        cand     = r_r | (NRM_W'(1) << r_bit);
        cand_ok  = cand <= NRM_W'(ONE_Q);
        t        = {cand, 1'b0} - T_W'(1);
        t2_full  = (2*T_W)'(t) * (2*T_W)'(t);
        phi      = PLO_W'(r_t2) * PLO_W'(r_len2[LEN_W-1 -: HI_W]);
        prod     = {phi[PROD_W-LO_W-1:0], {LO_W{1'b0}}} + PROD_W'(r_plo);
        rhs      = PROD_W'({r_sq[r_k], {RHS_SH{1'b0}}});
        keep     = prod <= rhs;
        step_r   = (r_state == S_P2 && keep) ? r_cand : r_r;
        step_adv = (r_state == S_P2) || (r_state == S_T2 && !cand_ok);
    end

    // finished block result with the normaliser outputs merged in
    always_comb begin
        res_done              = r_res;
        res_done.normal_x_out = r_nres[0];
        res_done.normal_y_out = r_nres[1];
        res_done.normal_z_out = r_nres[2];
        res_done.zero_normal  = r_zero;
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = in_acc ? S_ADDR : S_IDLE;
            S_ADDR:  n_state = r_ss ? S_RD : S_BYP;
            S_RD:    n_state = S_MOD;
            S_MOD:   n_state = done_blk ? S_SQ : S_IDLE;
            S_BYP:   n_state = out_free ? S_IDLE : S_BYP;
            S_SQ:    n_state = (r_k == 2'd2) ? S_LEN : S_SQ;
            S_LEN:   n_state = (len2 == '0) ? S_OUT : S_T2;
            S_T2:    begin
                if (cand_ok) begin
                    n_state = S_P1;
                end else if (r_bit == 4'd0 && r_k == 2'd2) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_T2;
                end
            end
            S_P1:    n_state = S_P2;
            S_P2:    n_state = (r_bit == 4'd0 && r_k == 2'd2) ? S_OUT : S_T2;
            S_OUT:   n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ic    <= '0;
            r_rp    <= 2'd0;
            r_orow  <= 12'd0;
            r_k     <= 2'd0;
            r_bit   <= 4'd12;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_ic   <= acc_ic;
                r_rp   <= acc_rp;
                r_orow <= acc_orow;
            end
            if (r_state == S_MOD || (r_state == S_BYP && out_free)) begin
                r_ic   <= adv_ic;
                r_rp   <= adv_rp;
                r_orow <= adv_orow;
            end
            if (r_state == S_MOD || r_state == S_LEN) begin
                r_k   <= 2'd0;
                r_bit <= 4'd12;
            end
            if (r_state == S_SQ && r_k != 2'd2) begin
                r_k <= r_k + 2'd1;
            end
            if (step_adv) begin
                if (r_bit == 4'd0) begin
                    r_bit <= 4'd12;
                    r_k   <= r_k + 2'd1;
                end else begin
                    r_bit <= r_bit - 4'd1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (r_state == S_ADDR) begin
            r_col <= ADDR_W'(qq);
            r_sx  <= sx_calc;
        end
        if (r_state == S_MOD) begin
            r_res.red_out      <= c_rnd[0][19:4];
            r_res.green_out    <= c_rnd[1][19:4];
            r_res.blue_out     <= c_rnd[2][19:4];
            r_res.depth_out    <= d_rnd[19:4];
            r_res.end_of_frame <= eof_ss;
            r_res.normal_x_out <= '0;
            r_res.normal_y_out <= '0;
            r_res.normal_z_out <= '0;
            r_res.zero_normal  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_s[i] <= new_n[i];
            end
        end
        if (r_state == S_SQ) begin
            r_sq[r_k] <= SQ_W'(r_s[r_k]) * SQ_W'(r_s[r_k]);
        end
        if (r_state == S_LEN) begin
            r_len2 <= len2;
            r_r    <= '0;
            r_zero <= (len2 == '0);
            if (len2 == '0) begin
                for (int i = 0; i < 3; i++) begin
                    r_nres[i] <= '0;
                end
            end
        end
        if (r_state == S_T2) begin
            r_cand <= cand;
            r_t2   <= t2_full[T2_W-1:0];
        end
        if (r_state == S_P1) begin
            r_plo <= PLO_W'(r_t2) * PLO_W'(r_len2[LO_W-1:0]);
        end
        if (step_adv) begin
            if (r_bit == 4'd0) begin
                r_nres[r_k] <= step_r;
                r_r         <= '0;
            end else begin
                r_r <= step_r;
            end
        end
        if (out_load) begin
            if (r_state == S_BYP) begin
                r_out.red_out      <= r_in.red_in;
                r_out.green_out    <= r_in.green_in;
                r_out.blue_out     <= r_in.blue_in;
                r_out.normal_x_out <= r_in.normal_x_in;
                r_out.normal_y_out <= r_in.normal_y_in;
                r_out.normal_z_out <= r_in.normal_z_in;
                r_out.depth_out    <= r_in.depth_in;
                r_out.zero_normal  <= 1'b0;
                r_out.end_of_frame <= eof_byp;
            end else begin
                r_out <= res_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BDS3_ASSERT_NXT(a_accept_goes_to_addr, in_acc, r_state == S_ADDR)
    `BDS3_ASSERT_IMP(a_zero_flag_clears_normal, o_out_valid && o_out_data.zero_normal, o_out_data.normal_x_out == '0 && o_out_data.normal_y_out == '0 && o_out_data.normal_z_out == '0)
    `BDS3_ASSERT_IMP(a_sum_write_only_supersample, ram_we, r_ss)
    `BDS3_ASSERT_IMP(a_unit_result_range, r_state == S_OUT, r_nres[0] <= NRM_W'(ONE_Q) && r_nres[1] <= NRM_W'(ONE_Q) && r_nres[2] <= NRM_W'(ONE_Q))

endmodule

// File: sv/bds3_ram.sv
module bds3_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
